// ----- sv/cfpl_pkg.sv -----
package cfpl_pkg;

  // Field widths of the transaction payloads and registers
  localparam int PAGE_W = 10;
  localparam int CNT_W  = 11;
  localparam int ACT_W  = 3;
  localparam int STAT_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 11;

  // Default geometry
  localparam int DEF_PAGE_COUNT  = 1024;
  localparam int DEF_COLOR_COUNT = 16;

  // Shift of the reciprocal used to split off the color
  localparam int COLOR_SHIFT = 20;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_INS_FREE = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INS_ZERO = 3'd1;
  localparam logic [ACT_W-1:0] ACT_REM_ANY  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_REM_ZERO = 3'd3;
  localparam logic [ACT_W-1:0] ACT_UNLINK   = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE     = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_LIST  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_ALREADY   = 3'd4;

  // Page location codes
  localparam logic [1:0] WHERE_NONE = 2'd0;
  localparam logic [1:0] WHERE_FREE = 2'd1;
  localparam logic [1:0] WHERE_ZERO = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOWEST   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGHEST  = 2'd3;

  // Register reset values
  localparam logic [CNT_W-1:0]  RST_LOW_THR  = 11'd64;
  localparam logic [CNT_W-1:0]  RST_HIGH_THR = 11'd512;
  localparam logic [PAGE_W-1:0] RST_LOWEST   = 10'd1;
  localparam logic [PAGE_W-1:0] RST_HIGHEST  = 10'd1023;

  // Outcome of the check step
  typedef enum logic [1:0] {
    KIND_ERR = 2'd0,
    KIND_INS = 2'd1,
    KIND_UNL = 2'd2
  } kind_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;
    logic accept;
    logic color;
    logic check;
    logic ins1;
    logic ins2;
    logic ins3;
    logic unl;
    logic err;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic  clear_done;
    logic  slot_free;
    kind_t kind;
  } sts_t;

endpackage

// ----- sv/cfpl_in_if.sv -----
interface cfpl_in_if;
  logic                            valid;
  logic                            ready;
  logic [cfpl_pkg::ACT_W-1:0]      action;
  logic [cfpl_pkg::PAGE_W-1:0]     page_index;

  modport source (output valid, output action, output page_index, input ready);
  modport sink (input valid, input action, input page_index, output ready);
endinterface

// ----- sv/cfpl_out_if.sv -----
interface cfpl_out_if;
  logic                            valid;
  logic                            ready;
  logic [cfpl_pkg::PAGE_W-1:0]     page;
  logic [cfpl_pkg::STAT_W-1:0]     status;
  logic                            needs_zeroing;
  logic                            low_memory_event;
  logic                            high_memory_event;
  logic [cfpl_pkg::CNT_W-1:0]      available_count;

  modport source (output valid, output page, output status, output needs_zeroing,
                  output low_memory_event, output high_memory_event,
                  output available_count, input ready);
  modport sink (input valid, input page, input status, input needs_zeroing,
                input low_memory_event, input high_memory_event,
                input available_count, output ready);
endinterface

// ----- sv/colored_free_page_list_manager.sv -----
// Each accepted request runs through the color and check steps, then the insert steps
// for an insertion, or the unlink or refusal step otherwise. One transaction is in
// flight at a time, so a new request is accepted only once the last result has been
// written; a held result adds its stall. The page link memories, with one write port
// each, set the insert path. Reset (rst_n, synchronous) starts a clearing sweep over the
// location and color end stores; no transaction is taken during it, configuration writes are.
module colored_free_page_list_manager #(
  parameter int PAGE_COUNT  = cfpl_pkg::DEF_PAGE_COUNT,
  parameter int COLOR_COUNT = cfpl_pkg::DEF_COLOR_COUNT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cfpl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cfpl_pkg::CFG_DATA_W-1:0] cfg_data,
  cfpl_in_if.sink                         in_ch,
  cfpl_out_if.source                      out_ch
);

  cfpl_pkg::cmd_t cmd;
  cfpl_pkg::sts_t sts;

  // Sequencer
  cfpl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Lists, memories and result register
  cfpl_dp #(
    .PAGE_COUNT  (PAGE_COUNT),
    .COLOR_COUNT (COLOR_COUNT)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_action             (in_ch.action),
    .in_page_index         (in_ch.page_index),
    .cmd                   (cmd),
    .sts                   (sts),
    .out_valid             (out_ch.valid),
    .out_ready             (out_ch.ready),
    .out_page              (out_ch.page),
    .out_status            (out_ch.status),
    .out_needs_zeroing     (out_ch.needs_zeroing),
    .out_low_memory_event  (out_ch.low_memory_event),
    .out_high_memory_event (out_ch.high_memory_event),
    .out_available_count   (out_ch.available_count)
  );

endmodule

// ----- sv/cfpl_ram.sv -----
module cfpl_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/cfpl_ctrl.sv -----
module cfpl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cfpl_pkg::sts_t    sts,
  output cfpl_pkg::cmd_t    cmd
);

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_COLOR = 9'b000000100,
    ST_CHECK = 9'b000001000,
    ST_INS1  = 9'b000010000,
    ST_INS2  = 9'b000100000,
    ST_INS3  = 9'b001000000,
    ST_UNL   = 9'b010000000,
    ST_ERR   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (sts.clear_done) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_COLOR;
      ST_COLOR: state_nxt = ST_CHECK;
      ST_CHECK: begin
        case (sts.kind)
          cfpl_pkg::KIND_INS: state_nxt = ST_INS1;
          cfpl_pkg::KIND_UNL: state_nxt = ST_UNL;
          default:            state_nxt = ST_ERR;
        endcase
      end
      ST_INS1:  state_nxt = ST_INS2;
      ST_INS2:  state_nxt = ST_INS3;
      ST_INS3, ST_UNL, ST_ERR: if (sts.slot_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Commands; final steps fire only when the result register is free
  assign in_ready   = (state_r == ST_IDLE);
  assign cmd.clear  = (state_r == ST_CLEAR);
  assign cmd.accept = (state_r == ST_IDLE) && in_valid;
  assign cmd.color  = (state_r == ST_COLOR);
  assign cmd.check  = (state_r == ST_CHECK);
  assign cmd.ins1   = (state_r == ST_INS1);
  assign cmd.ins2   = (state_r == ST_INS2);
  assign cmd.ins3   = (state_r == ST_INS3) && sts.slot_free;
  assign cmd.unl    = (state_r == ST_UNL) && sts.slot_free;
  assign cmd.err    = (state_r == ST_ERR) && sts.slot_free;

endmodule

// ----- sv/cfpl_dp.sv -----
module cfpl_dp #(
  parameter int PAGE_COUNT  = cfpl_pkg::DEF_PAGE_COUNT,
  parameter int COLOR_COUNT = cfpl_pkg::DEF_COLOR_COUNT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cfpl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cfpl_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [cfpl_pkg::ACT_W-1:0]        in_action,
  input  logic [cfpl_pkg::PAGE_W-1:0]       in_page_index,
  input  cfpl_pkg::cmd_t                    cmd,
  output cfpl_pkg::sts_t                    sts,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [cfpl_pkg::PAGE_W-1:0]       out_page,
  output logic [cfpl_pkg::STAT_W-1:0]       out_status,
  output logic                              out_needs_zeroing,
  output logic                              out_low_memory_event,
  output logic                              out_high_memory_event,
  output logic [cfpl_pkg::CNT_W-1:0]        out_available_count
);

  localparam int PW   = cfpl_pkg::PAGE_W;
  localparam int CTW  = cfpl_pkg::CNT_W;
  localparam int AW   = $clog2(PAGE_COUNT);
  localparam int CW   = (COLOR_COUNT > 1) ? $clog2(COLOR_COUNT) : 1;
  localparam int CDEPTH = 2 << CW;
  localparam int CLR_N  = (PAGE_COUNT > CDEPTH) ? PAGE_COUNT : CDEPTH;
  localparam int CLW    = $clog2(CLR_N);
  localparam int SH     = cfpl_pkg::COLOR_SHIFT;
  localparam int MUL    = (1 << SH) / COLOR_COUNT;
  localparam int PROD_W = PW + SH;

  // Configuration registers
  logic [CTW-1:0] low_thr_r, high_thr_r;
  logic [PW-1:0]  lowest_r, highest_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_thr_r  <= cfpl_pkg::RST_LOW_THR;
      high_thr_r <= cfpl_pkg::RST_HIGH_THR;
      lowest_r   <= cfpl_pkg::RST_LOWEST;
      highest_r  <= cfpl_pkg::RST_HIGHEST;
    end else if (cfg_we) begin
      case (cfg_index)
        cfpl_pkg::REG_LOW_THR:  low_thr_r  <= cfg_data;
        cfpl_pkg::REG_HIGH_THR: high_thr_r <= cfg_data;
        cfpl_pkg::REG_LOWEST:   lowest_r   <= cfg_data[PW-1:0];
        cfpl_pkg::REG_HIGHEST:  highest_r  <= cfg_data[PW-1:0];
        default: ;
      endcase
    end
  end

  // Clearing sweep over the location store and the color head/tail stores
  logic [CLW-1:0] clr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear) begin
      clr_r <= clr_r + CLW'(1);
    end
  end
  assign sts.clear_done = (clr_r == CLW'(CLR_N - 1));

  // List heads and tails, index 0 free, 1 zeroed
  logic [1:0][PW-1:0] first_r, first_nxt, last_r, last_nxt;

  // Transaction context
  logic [cfpl_pkg::ACT_W-1:0]  act_r;
  logic [PW-1:0]               p_r;
  logic                        l_r;
  logic                        z_r;
  logic [PW-1:0]               q_r;
  logic [CW-1:0]               c_r;
  logic [cfpl_pkg::STAT_W-1:0] stat_r;
  logic [PW-1:0]               cnb_r;

  // Count and events
  logic [CTW-1:0] avail_r, avail_nxt;
  logic           low_r, low_nxt, high_r, high_nxt;

  // Memory ports
  logic          wh_we;  logic [AW-1:0] wh_wa;  logic [1:0]    wh_wd;  logic [1:0]    wh_rd;
  logic          pn_we;  logic [AW-1:0] pn_wa;  logic [PW-1:0] pn_wd;  logic [PW-1:0] pn_rd;
  logic          pp_we;  logic [AW-1:0] pp_wa;  logic [PW-1:0] pp_wd;  logic [PW-1:0] pp_rd;
  logic          cn_we;  logic [AW-1:0] cn_wa;  logic [PW-1:0] cn_wd;  logic [PW-1:0] cn_rd;
  logic          cp_we;  logic [AW-1:0] cp_wa;  logic [PW-1:0] cp_wd;  logic [PW-1:0] cp_rd;
  logic          cf_we;  logic [CW:0]   cf_wa;  logic [PW-1:0] cf_wd;  logic [PW-1:0] cf_rd;
  logic          cl_we;  logic [CW:0]   cl_wa;  logic [PW-1:0] cl_wd;  logic [PW-1:0] cl_rd;
  logic [AW-1:0] p_addr;
  logic [CW:0]   c_addr;

  assign p_addr = AW'(p_r);
  assign c_addr = {l_r, c_r};

  cfpl_ram #(.WIDTH(2),  .DEPTH(PAGE_COUNT)) u_where (.clk(clk), .we(wh_we), .waddr(wh_wa),
    .wdata(wh_wd), .raddr(p_addr), .rdata(wh_rd));
  cfpl_ram #(.WIDTH(PW), .DEPTH(PAGE_COUNT)) u_pnext (.clk(clk), .we(pn_we), .waddr(pn_wa),
    .wdata(pn_wd), .raddr(p_addr), .rdata(pn_rd));
  cfpl_ram #(.WIDTH(PW), .DEPTH(PAGE_COUNT)) u_pprev (.clk(clk), .we(pp_we), .waddr(pp_wa),
    .wdata(pp_wd), .raddr(p_addr), .rdata(pp_rd));
  cfpl_ram #(.WIDTH(PW), .DEPTH(PAGE_COUNT)) u_cnext (.clk(clk), .we(cn_we), .waddr(cn_wa),
    .wdata(cn_wd), .raddr(p_addr), .rdata(cn_rd));
  cfpl_ram #(.WIDTH(PW), .DEPTH(PAGE_COUNT)) u_cprev (.clk(clk), .we(cp_we), .waddr(cp_wa),
    .wdata(cp_wd), .raddr(p_addr), .rdata(cp_rd));
  cfpl_ram #(.WIDTH(PW), .DEPTH(CDEPTH)) u_cfirst (.clk(clk), .we(cf_we), .waddr(cf_wa),
    .wdata(cf_wd), .raddr(c_addr), .rdata(cf_rd));
  cfpl_ram #(.WIDTH(PW), .DEPTH(CDEPTH)) u_clast (.clk(clk), .we(cl_we), .waddr(cl_wa),
    .wdata(cl_wd), .raddr(c_addr), .rdata(cl_rd));

  // Removal picks its list at accept time
  logic          sel_zero;
  logic [PW-1:0] head_a, head_b;
  logic          act_ins, act_rem;
  assign sel_zero = (in_action == cfpl_pkg::ACT_REM_ZERO);
  assign head_a   = first_r[sel_zero];
  assign head_b   = first_r[!sel_zero];
  assign act_ins  = (in_action == cfpl_pkg::ACT_INS_FREE) ||
                    (in_action == cfpl_pkg::ACT_INS_ZERO);
  assign act_rem  = (in_action == cfpl_pkg::ACT_REM_ANY) || sel_zero;

  // Color split: quotient by reciprocal, then one correcting subtract
  logic [PROD_W-1:0] prod;
  logic [PW-1:0]     qc, rem, col;
  assign prod = PROD_W'(p_r) * PROD_W'(MUL);
  assign qc   = q_r * PW'(COLOR_COUNT);
  assign rem  = p_r - qc;
  assign col  = (rem >= PW'(COLOR_COUNT)) ? (rem - PW'(COLOR_COUNT)) : rem;

  // Check step decision
  logic                        out_of_range, in_range_ins;
  logic [cfpl_pkg::STAT_W-1:0] chk_stat;
  cfpl_pkg::kind_t             chk_kind;
  assign out_of_range = (int'(p_r) >= PAGE_COUNT);
  assign in_range_ins = (p_r != '0) && !out_of_range && (p_r >= lowest_r) &&
                        (p_r <= highest_r);

  always_comb begin
    chk_stat = cfpl_pkg::STAT_OK;
    chk_kind = cfpl_pkg::KIND_ERR;
    case (act_r)
      cfpl_pkg::ACT_INS_FREE, cfpl_pkg::ACT_INS_ZERO: begin
        if (!in_range_ins) chk_stat = cfpl_pkg::STAT_RANGE;
        else if (wh_rd != cfpl_pkg::WHERE_NONE) chk_stat = cfpl_pkg::STAT_ALREADY;
        else chk_kind = cfpl_pkg::KIND_INS;
      end
      cfpl_pkg::ACT_REM_ANY, cfpl_pkg::ACT_REM_ZERO: begin
        if (p_r == '0) chk_stat = cfpl_pkg::STAT_EMPTY;
        else chk_kind = cfpl_pkg::KIND_UNL;
      end
      cfpl_pkg::ACT_UNLINK: begin
        if (out_of_range) chk_stat = cfpl_pkg::STAT_RANGE;
        else if (wh_rd == cfpl_pkg::WHERE_NONE) chk_stat = cfpl_pkg::STAT_NOT_LIST;
        else chk_kind = cfpl_pkg::KIND_UNL;
      end
      default: ;
    endcase
  end
  assign sts.kind = chk_kind;

  // Context registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r <= in_action;
      z_r   <= 1'b0;
      l_r   <= in_action[0];
      if (act_ins || (in_action == cfpl_pkg::ACT_UNLINK)) begin
        p_r <= in_page_index;
      end else if (act_rem) begin
        if (head_a != '0) begin
          p_r <= head_a;
          l_r <= sel_zero;
          z_r <= 1'b0;
        end else begin
          p_r <= head_b;
          l_r <= !sel_zero;
          z_r <= sel_zero && (head_b != '0);
        end
      end else begin
        p_r <= '0;
      end
    end
    if (cmd.color) begin
      q_r <= prod[PROD_W-1:SH];
    end
    if (cmd.check) begin
      c_r    <= CW'(col);
      stat_r <= chk_stat;
      if (act_r == cfpl_pkg::ACT_UNLINK) begin
        l_r <= (wh_rd == cfpl_pkg::WHERE_ZERO);
      end
    end
    if (cmd.ins2) begin
      cnb_r <= l_r ? cf_rd : cl_rd;
    end
  end

  // Memory writes for each step
  logic [PW-1:0] nb;
  assign nb = l_r ? cf_rd : cl_rd;

  always_comb begin
    wh_we = 1'b0; wh_wa = p_addr; wh_wd = cfpl_pkg::WHERE_NONE;
    pn_we = 1'b0; pn_wa = p_addr; pn_wd = '0;
    pp_we = 1'b0; pp_wa = p_addr; pp_wd = '0;
    cn_we = 1'b0; cn_wa = p_addr; cn_wd = '0;
    cp_we = 1'b0; cp_wa = p_addr; cp_wd = '0;
    cf_we = 1'b0; cf_wa = c_addr; cf_wd = p_r;
    cl_we = 1'b0; cl_wa = c_addr; cl_wd = p_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    if (cmd.clear) begin
      wh_we = 1'b1; wh_wa = clr_r[AW-1:0];
      cf_we = 1'b1; cf_wa = clr_r[CW:0]; cf_wd = '0;
      cl_we = 1'b1; cl_wa = clr_r[CW:0]; cl_wd = '0;
    end
    // own page links
    if (cmd.ins1) begin
      pn_we = 1'b1; pn_wd = l_r ? first_r[1] : '0;
      pp_we = 1'b1; pp_wd = l_r ? '0 : last_r[0];
    end
    // neighbor page link, own color links, list and color ends
    if (cmd.ins2) begin
      if (!l_r) begin
        if (last_r[0] != '0) begin
          pn_we = 1'b1; pn_wa = AW'(last_r[0]); pn_wd = p_r;
        end else begin
          first_nxt[0] = p_r;
        end
        last_nxt[0] = p_r;
        cl_we = 1'b1;
        cf_we = (nb == '0);
      end else begin
        if (first_r[1] != '0) begin
          pp_we = 1'b1; pp_wa = AW'(first_r[1]); pp_wd = p_r;
        end else begin
          last_nxt[1] = p_r;
        end
        first_nxt[1] = p_r;
        cf_we = 1'b1;
        cl_we = (nb == '0);
      end
      cn_we = 1'b1; cn_wd = l_r ? nb : '0;
      cp_we = 1'b1; cp_wd = l_r ? '0 : nb;
    end
    // neighbor color link and location
    if (cmd.ins3) begin
      wh_we = 1'b1; wh_wd = l_r ? cfpl_pkg::WHERE_ZERO : cfpl_pkg::WHERE_FREE;
      if (cnb_r != '0) begin
        if (!l_r) begin
          cn_we = 1'b1; cn_wa = AW'(cnb_r); cn_wd = p_r;
        end else begin
          cp_we = 1'b1; cp_wa = AW'(cnb_r); cp_wd = p_r;
        end
      end
    end
    // unlink: bridge both neighbors in one step
    if (cmd.unl) begin
      wh_we = 1'b1;
      if (pn_rd != '0) begin
        pp_we = 1'b1; pp_wa = AW'(pn_rd); pp_wd = pp_rd;
      end else begin
        last_nxt[l_r] = pp_rd;
      end
      if (pp_rd != '0) begin
        pn_we = 1'b1; pn_wa = AW'(pp_rd); pn_wd = pn_rd;
      end else begin
        first_nxt[l_r] = pn_rd;
      end
      if (cn_rd != '0) begin
        cp_we = 1'b1; cp_wa = AW'(cn_rd); cp_wd = cp_rd;
      end else begin
        cl_we = 1'b1; cl_wd = cp_rd;
      end
      if (cp_rd != '0) begin
        cn_we = 1'b1; cn_wa = AW'(cp_rd); cn_wd = cn_rd;
      end else begin
        cf_we = 1'b1; cf_wd = cn_rd;
      end
    end
  end

  // Available count and memory events
  always_comb begin
    avail_nxt = avail_r;
    low_nxt   = low_r;
    high_nxt  = high_r;
    if (cmd.ins3) begin
      avail_nxt = avail_r + CTW'(1);
      if (avail_nxt == low_thr_r) low_nxt = 1'b0;
      else if (avail_nxt == high_thr_r) high_nxt = 1'b1;
    end else if (cmd.unl) begin
      if (avail_r == high_thr_r) high_nxt = 1'b0;
      else if (avail_r == low_thr_r) low_nxt = 1'b1;
      avail_nxt = avail_r - CTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= '0;
      last_r  <= '0;
      avail_r <= '0;
      low_r   <= 1'b0;
      high_r  <= 1'b0;
    end else begin
      first_r <= first_nxt;
      last_r  <= last_nxt;
      avail_r <= avail_nxt;
      low_r   <= low_nxt;
      high_r  <= high_nxt;
    end
  end

  // Result register
  logic finish;
  logic out_valid_r;
  assign finish = cmd.ins3 || cmd.unl || cmd.err;
  assign sts.slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_page              <= p_r;
      out_status            <= cmd.err ? stat_r : cfpl_pkg::STAT_OK;
      out_needs_zeroing     <= cmd.unl && z_r;
      out_low_memory_event  <= low_nxt;
      out_high_memory_event <= high_nxt;
      out_available_count   <= avail_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
